/* rtl/hcv_pkg.sv */
// ----------------------------------------------------------------------------
// hcv_pkg
// Shared types, codes and helper functions for the variable-length Hamming
// codec: configuration bundle, queue entry formats and status codes.
// ----------------------------------------------------------------------------
package hcv_pkg;

    localparam int MAX_CODE_BITS = 63;
    localparam int LEN_W         = 6;
    localparam int SYND_W        = 6;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic CFG_CODE_LENGTH = 1'b0;
    localparam logic CFG_DATA_LENGTH = 1'b1;

    localparam logic [LEN_W-1:0] CODE_LENGTH_RESET = 6'd7;
    localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = 6'd4;
    localparam logic [LEN_W-1:0] MIN_CODE_LENGTH   = 6'd3;

    typedef enum logic [1:0] {
        ST_CLEAN      = 2'd0,
        ST_CORRECTED  = 2'd1,
        ST_BEYOND     = 2'd2,
        ST_MISMATCH   = 2'd3
    } hcv_status_t;

    typedef struct packed {
        logic [LEN_W-1:0] code_length;
        logic [LEN_W-1:0] data_length;
    } hcv_cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic                     func;
        logic [MAX_CODE_BITS-1:0] word;
        logic [SYND_W-1:0]        synd;
        logic                     bad;
        logic [LEN_W-1:0]         n;
    } hcv_mid_t;

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] word;
        hcv_status_t              status;
        logic [SYND_W-1:0]        epos;
    } hcv_res_t;

    function automatic logic is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // number of power-of-two positions not above n
    function automatic logic [LEN_W-1:0] check_count(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < SYND_W; k++) begin
            if ((7'd1 << k) <= {1'b0, n}) begin
                cnt = cnt + 6'd1;
            end
        end
        return cnt;
    endfunction

endpackage

/* rtl/hcv_front.sv */
// ----------------------------------------------------------------------------
// hcv_front
// Accepts words, lays out the codeword (scatter for encode, length mask for
// decode), computes the syndrome and length check, and queues the result.
// ----------------------------------------------------------------------------
module hcv_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             func,
    input  logic [hcv_pkg::MAX_CODE_BITS-1:0] word_in,
    input  hcv_pkg::hcv_cfg_t                cfg,
    output logic                             mid_valid,
    output hcv_pkg::hcv_mid_t                mid_item,
    input  logic                             mid_pop
);
    import hcv_pkg::*;

    hcv_mid_t             mem_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 push_ok;
    logic [MAX_CODE_BITS-1:0] cw;
    logic [SYND_W-1:0]    synd;
    logic                 bad;
    hcv_mid_t             entry;

    // codeword layout and syndrome
    always_comb
    begin
        int j;
        j    = 0;
        cw   = '0;
        synd = '0;
        for (int p = 1; p <= MAX_CODE_BITS; p++)
        begin
            if (func == FUNC_DECODE)
            begin
                cw[p-1] = word_in[p-1] & (6'(p) <= cfg.code_length);
            end
            else if (!is_pow2(p))
            begin
                cw[p-1] = word_in[j] & (6'(p) <= cfg.code_length);
                j = j + 1;
            end
        end
        for (int p = 1; p <= MAX_CODE_BITS; p++)
        begin
            if (cw[p-1])
            begin
                synd = synd ^ 6'(p);
            end
        end
    end

    assign bad = (cfg.code_length < MIN_CODE_LENGTH) ||
                 (cfg.data_length != (cfg.code_length - check_count(cfg.code_length)));

    always_comb
    begin
        entry.func = func;
        entry.word = cw;
        entry.synd = synd;
        entry.bad  = bad;
        entry.n    = cfg.code_length;
    end

    assign full      = (count_reg == 2'd2);
    assign push_ok   = push && !full;
    assign mid_valid = (count_reg != 2'd0);
    assign mid_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ mid_pop;
        count_next  = count_reg + {1'b0, push_ok} - {1'b0, mid_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("front queue count out of range");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !mid_pop) |=> mid_valid)
        else $error("accepted word not visible to back");

endmodule

/* rtl/hcv_back.sv */
// ----------------------------------------------------------------------------
// hcv_back
// Takes classified words, inserts check bits or corrects and extracts data,
// and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module hcv_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              mid_valid,
    input  hcv_pkg::hcv_mid_t                 mid_item,
    output logic                              mid_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic [hcv_pkg::MAX_CODE_BITS-1:0] word_out,
    output logic [1:0]                        status,
    output logic [hcv_pkg::SYND_W-1:0]        error_position
);
    import hcv_pkg::*;

    hcv_res_t             mem_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 pop_ok;
    hcv_res_t             res;
    hcv_res_t             head;
    logic [MAX_CODE_BITS-1:0] w;

    always_comb
    begin
        int j;
        j          = 0;
        w          = mid_item.word;
        res.word   = '0;
        res.status = ST_CLEAN;
        res.epos   = '0;
        if (mid_item.func == FUNC_ENCODE)
        begin
            res.word = w;
            for (int k = 0; k < SYND_W; k++)
            begin
                if ((7'd1 << k) <= {1'b0, mid_item.n})
                begin
                    res.word[(1 << k) - 1] = mid_item.synd[k];
                end
            end
        end
        else
        begin
            if (!mid_item.bad && (mid_item.synd != '0))
            begin
                if (mid_item.synd <= mid_item.n)
                begin
                    for (int p = 1; p <= MAX_CODE_BITS; p++)
                    begin
                        if (mid_item.synd == 6'(p))
                        begin
                            w[p-1] = ~w[p-1];
                        end
                    end
                    res.status = ST_CORRECTED;
                    res.epos   = mid_item.synd;
                end
                else
                begin
                    res.status = ST_BEYOND;
                end
            end
            // pull data bits from the non power-of-two positions
            for (int p = 1; p <= MAX_CODE_BITS; p++)
            begin
                if (!is_pow2(p))
                begin
                    res.word[j] = w[p-1];
                    j = j + 1;
                end
            end
        end
        if (mid_item.bad)
        begin
            res.status = ST_MISMATCH;
            res.epos   = '0;
        end
    end

    assign empty   = (count_reg == 2'd0);
    assign pop_ok  = pop && !empty;
    assign mid_pop = mid_valid && ((count_reg != 2'd2) || pop_ok);

    assign head           = mem_reg[rd_ptr_reg];
    assign word_out       = head.word;
    assign status         = head.status;
    assign error_position = head.epos;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ mid_pop;
        rd_ptr_next = rd_ptr_reg ^ pop_ok;
        count_next  = count_reg + {1'b0, mid_pop} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> mid_valid)
        else $error("back took from empty front queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue count out of range");

    a_corrected_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_CORRECTED)) |-> (error_position != '0))
        else $error("corrected word without position");

    a_clean_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_CORRECTED)) |-> (error_position == '0))
        else $error("position reported without correction");

endmodule

/* rtl/hamming_codec_variable_length_top.sv */
// ----------------------------------------------------------------------------
// hamming_codec_variable_length_top
// Single-error-correcting Hamming encoder/decoder with programmable length.
// ----------------------------------------------------------------------------
// usage:
//   input side is a queue: drive func and word_in with push; a word is taken
//   on a clock edge with push high and full low. func 0 encodes a data word,
//   func 1 decodes a codeword.
//   result side is a queue: while empty is low the oldest result sits on
//   word_out, status and error_position; pop high takes it.
//   config: cfg_valid with cfg_index (0 code_length, 1 data_length) and
//   cfg_data; cfg_ready is always high. write only while the codec is idle.
//   path: a word moves from the middle queue to the output queue, whose
//   head sits on the result ports. throughput: one word per clock unless
//   the output queue fills; the front stage (syndrome xor tree) and the
//   back stage (correction and extraction) each end in a queue register.
//   reset: both queues empty, code_length 7, data_length 4.
//   stall: the output queue holds two results, then the two-entry middle
//   queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module hamming_codec_variable_length_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              func,
    input  logic [hcv_pkg::MAX_CODE_BITS-1:0] word_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [hcv_pkg::MAX_CODE_BITS-1:0] word_out,
    output logic [1:0]                        status,
    output logic [hcv_pkg::SYND_W-1:0]        error_position,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [hcv_pkg::LEN_W-1:0]         cfg_data
);
    import hcv_pkg::*;

    logic [LEN_W-1:0] code_length_reg, code_length_next;
    logic [LEN_W-1:0] data_length_reg, data_length_next;
    hcv_cfg_t         cfg;
    logic             mid_valid;
    logic             mid_pop;
    hcv_mid_t         mid_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        code_length_next = code_length_reg;
        data_length_next = data_length_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CODE_LENGTH: code_length_next = cfg_data;
                CFG_DATA_LENGTH: data_length_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LENGTH_RESET;
            data_length_reg <= DATA_LENGTH_RESET;
        end
        else
        begin
            code_length_reg <= code_length_next;
            data_length_reg <= data_length_next;
        end
    end

    assign cfg.code_length = code_length_reg;
    assign cfg.data_length = data_length_reg;

    hcv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .word_in   (word_in),
        .cfg       (cfg),
        .mid_valid (mid_valid),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop)
    );

    hcv_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .mid_valid      (mid_valid),
        .mid_item       (mid_item),
        .mid_pop        (mid_pop),
        .empty          (empty),
        .pop            (pop),
        .word_out       (word_out),
        .status         (status),
        .error_position (error_position)
    );

endmodule

/* tb/sv/hcv_tb_pkg.sv */
// ----------------------------------------------------------------------------
// hcv_tb_pkg
// Scoreboard for the variable-length Hamming codec bench: tracks the two
// length registers, computes the expected result of every accepted word and
// checks the results popped from the codec in order.
// ----------------------------------------------------------------------------
package hcv_tb_pkg;

    import hcv_pkg::*;

    class hamming_scoreboard;

        logic [LEN_W-1:0] code_len;
        logic [LEN_W-1:0] data_len;
        hcv_res_t         awaited[$];
        int               errors;
        int               checked;
        int               encodes;
        int               tally[4];

        function new();
            code_len = CODE_LENGTH_RESET;
            data_len = DATA_LENGTH_RESET;
            errors   = 0;
            checked  = 0;
            encodes  = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_register(logic idx, logic [LEN_W-1:0] value);
            if (idx == CFG_CODE_LENGTH)
                code_len = value;
            else
                data_len = value;
        endfunction

        // data bits that fit a code of n bits
        function int unsigned data_bits_for(int unsigned n);
            int unsigned checks;
            checks = 0;
            for (int unsigned p = 1; p <= n; p++)
                if ((p & (p - 1)) == 0)
                    checks++;
            return n - checks;
        endfunction

        function hcv_res_t codec_result(logic f, logic [MAX_CODE_BITS-1:0] w);
            int unsigned n;
            int unsigned j;
            int unsigned synd;
            bit          bad;
            logic [63:0] keep;
            logic [MAX_CODE_BITS-1:0] cw;
            hcv_res_t    r;
            n = code_len;
            bad = (n < MIN_CODE_LENGTH) || (n > MAX_CODE_BITS);
            if (n > MAX_CODE_BITS)
                n = MAX_CODE_BITS;
            if (data_len != data_bits_for(n))
                bad = 1;
            r = '0;
            r.status = ST_CLEAN;
            synd = 0;
            j = 0;
            if (f == FUNC_ENCODE)
            begin
                for (int unsigned p = 1; p <= n; p++)
                begin
                    if ((p & (p - 1)) != 0)
                    begin
                        if (w[j])
                        begin
                            r.word[p-1] = 1'b1;
                            synd ^= p;
                        end
                        j++;
                    end
                end
                for (int unsigned p = 1; p <= n; p = p << 1)
                    if ((synd & p) != 0)
                        r.word[p-1] = 1'b1;
            end
            else
            begin
                keep = (64'd1 << n) - 64'd1;
                cw = w & keep[MAX_CODE_BITS-1:0];
                for (int unsigned p = 1; p <= n; p++)
                    if (cw[p-1])
                        synd ^= p;
                if (!bad && synd != 0)
                begin
                    if (synd <= n)
                    begin
                        cw[synd-1] = ~cw[synd-1];
                        r.status = ST_CORRECTED;
                        r.epos = SYND_W'(synd);
                    end
                    else
                    begin
                        r.status = ST_BEYOND;
                    end
                end
                for (int unsigned p = 1; p <= n; p++)
                begin
                    if ((p & (p - 1)) != 0)
                    begin
                        r.word[j] = cw[p-1];
                        j++;
                    end
                end
            end
            if (bad)
            begin
                r.status = ST_MISMATCH;
                r.epos = '0;
            end
            return r;
        endfunction

        task flag(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_word(logic f, logic [MAX_CODE_BITS-1:0] w);
            hcv_res_t r;
            r = codec_result(f, w);
            awaited.insert(awaited.size(), r);
            tally[r.status]++;
            if (f == FUNC_ENCODE)
                encodes++;
        endfunction

        task check_word(logic [MAX_CODE_BITS-1:0] w, logic [1:0] st,
                        logic [SYND_W-1:0] ep);
            hcv_res_t r;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result word %h with nothing awaited", w));
                return;
            end
            r = awaited.pop_front();
            checked++;
            if (w !== r.word)
                flag($sformatf("word_out %h, wanted %h", w, r.word));
            if (st !== r.status)
                flag($sformatf("status %0d, wanted %0d", st, r.status));
            if (ep !== r.epos)
                flag($sformatf("error_position %0d, wanted %0d", ep, r.epos));
        endtask

    endclass

endpackage

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Bench for the variable-length Hamming codec: directed corner words and
// random encode/decode traffic (mostly single-error codewords) over a range
// of valid and inconsistent length settings, with random stalls on both the
// push and pop sides, every result checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hcv_pkg::*;
    import hcv_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    logic                     func;
    logic [MAX_CODE_BITS-1:0] word_in;
    logic                     empty;
    logic                     pop;
    logic [MAX_CODE_BITS-1:0] word_out;
    logic [1:0]               status;
    logic [SYND_W-1:0]        error_position;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic                     cfg_index;
    logic [LEN_W-1:0]         cfg_data;

    hamming_scoreboard sb = new();
    bit                steady = 0;
    int unsigned       cycles = 0;
    int                settings = 0;

    hamming_codec_variable_length_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .func           (func),
        .word_in        (word_in),
        .empty          (empty),
        .pop            (pop),
        .word_out       (word_out),
        .status         (status),
        .error_position (error_position),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 24);
    endfunction

    // result side
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= !take_break();
            @(posedge clk);
            if (pop && !empty)
                sb.check_word(word_out, status, error_position);
        end
    end

    task automatic send_word(logic f, logic [MAX_CODE_BITS-1:0] w);
        @(negedge clk);
        while (take_break())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        func <= f;
        word_in <= w;
        @(posedge clk);
        while (full)
        begin
            @(negedge clk);
            @(posedge clk);
        end
        sb.note_word(f, w);
    endtask

    // drop push and let every awaited word come back
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_lengths(int unsigned n, int unsigned k);
        settle();
        write_reg(CFG_CODE_LENGTH, LEN_W'(n));
        write_reg(CFG_DATA_LENGTH, LEN_W'(k));
        settings++;
    endtask

    function automatic logic [MAX_CODE_BITS-1:0] codeword_of(logic [MAX_CODE_BITS-1:0] d);
        hcv_res_t r;
        r = sb.codec_result(FUNC_ENCODE, d);
        return r.word;
    endfunction

    task automatic run_random(int count);
        logic [63:0]              data;
        logic [63:0]              junk;
        logic [63:0]              above;
        logic [MAX_CODE_BITS-1:0] w;
        int unsigned              n;
        int unsigned              roll;
        int unsigned              pos;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            data = {$urandom, $urandom};
            junk = {$urandom, $urandom};
            n = sb.code_len;
            if (roll < 70)
            begin
                // codeword with at most one flip, sometimes two, and sometimes junk above n
                w = codeword_of(data[MAX_CODE_BITS-1:0]);
                pos = $urandom_range(n);
                if (pos != 0)
                    w[pos-1] = ~w[pos-1];
                if ($urandom_range(9) == 0)
                begin
                    pos = $urandom_range(n);
                    if (pos != 0)
                        w[pos-1] = ~w[pos-1];
                end
                if ($urandom_range(2) == 0)
                begin
                    above = junk & ~((64'd1 << n) - 64'd1);
                    w = w | above[MAX_CODE_BITS-1:0];
                end
                send_word(FUNC_DECODE, w);
            end
            else if (roll < 85)
                send_word(FUNC_ENCODE, data[MAX_CODE_BITS-1:0]);
            else
                send_word(FUNC_DECODE, data[MAX_CODE_BITS-1:0]);
        end
    endtask

    initial
    begin
        logic [MAX_CODE_BITS-1:0] cw;
        int unsigned              n;
        rst_n = 1'b0;
        push = 1'b0;
        func = FUNC_ENCODE;
        word_in = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CODE_LENGTH;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset lengths (7,4)
        settings++;
        cw = codeword_of(63'hB);
        send_word(FUNC_ENCODE, '0);
        send_word(FUNC_ENCODE, '1);
        send_word(FUNC_DECODE, '0);
        send_word(FUNC_DECODE, '1);
        send_word(FUNC_DECODE, cw ^ 63'h1);
        send_word(FUNC_DECODE, cw ^ 63'h40);
        send_word(FUNC_DECODE, cw ^ 63'h4 ^ {56'hF0F0F0F0F0F0F0, 7'h0});
        send_word(FUNC_DECODE, cw ^ 63'h3);
        run_random(60);

        // longest code, no stalls on either side
        set_lengths(63, 57);
        steady = 1;
        run_random(100);
        steady = 0;

        set_lengths(3, 1);
        send_word(FUNC_DECODE, 63'h7);
        run_random(50);

        // syndromes 6 and 7 fall outside a 5-bit code
        set_lengths(5, 2);
        send_word(FUNC_DECODE, 63'h14);
        send_word(FUNC_DECODE, 63'h1F);
        send_word(FUNC_ENCODE, 63'h3);
        run_random(50);

        set_lengths(12, 8);
        run_random(50);

        // inconsistent lengths
        set_lengths(2, 0);
        send_word(FUNC_ENCODE, '1);
        send_word(FUNC_DECODE, '1);
        run_random(30);

        set_lengths(0, 0);
        send_word(FUNC_DECODE, 63'h5);
        run_random(20);

        set_lengths(10, 5);
        send_word(FUNC_DECODE, codeword_of(63'h2A) ^ 63'h10);
        run_random(30);

        set_lengths(1, 0);
        run_random(10);

        repeat (6)
        begin
            n = $urandom_range(3, MAX_CODE_BITS);
            set_lengths(n, sb.data_bits_for(n));
            run_random(30);
        end

        set_lengths($urandom_range(3, MAX_CODE_BITS), $urandom_range(0, 63));
        run_random(30);

        settle();
        if (sb.awaited.size() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.awaited.size()));

        $display("run: %0d words checked (%0d encodes) across %0d length settings",
                 sb.checked, sb.encodes, settings);
        $display("outcomes: %0d clean, %0d corrected, %0d beyond length, %0d mismatch",
                 sb.tally[ST_CLEAN], sb.tally[ST_CORRECTED], sb.tally[ST_BEYOND],
                 sb.tally[ST_MISMATCH]);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
